// File: design/ire_pkg.sv
// Package for the interval range evaluator: widths, request types,
// operation and status codes, and saturating helpers. No dependencies.
`default_nettype none

package ire_pkg;

  localparam int EDGE_COUNT = 1024;
  localparam int EDGE_W     = $clog2(EDGE_COUNT);
  localparam int VALUE_W    = 48;
  localparam int FRAC_BITS  = 16;
  localparam int DIGIT_W    = 16;
  localparam int DIGITS     = VALUE_W / DIGIT_W;
  localparam int NUM_W      = VALUE_W + FRAC_BITS;
  localparam int ENTRY_W    = 2 * VALUE_W;

  typedef logic signed [VALUE_W-1:0] val_t;

  localparam val_t VMAX = {1'b0, {(VALUE_W-1){1'b1}}};
  localparam val_t VMIN = {1'b1, {(VALUE_W-1){1'b0}}};

  localparam logic [3:0] MODE_CONST  = 4'd0;
  localparam logic [3:0] MODE_INPUT  = 4'd1;
  localparam logic [3:0] MODE_ADD    = 4'd2;
  localparam logic [3:0] MODE_SUB    = 4'd3;
  localparam logic [3:0] MODE_MUL    = 4'd4;
  localparam logic [3:0] MODE_DIV    = 4'd5;
  localparam logic [3:0] MODE_SHL    = 4'd6;
  localparam logic [3:0] MODE_SHR    = 4'd7;
  localparam logic [3:0] MODE_ASSIGN = 4'd8;
  localparam logic [3:0] MODE_READ   = 4'd9;

  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_SAT  = 2'd1,
    ST_DIVZ = 2'd2
  } status_e;

  typedef struct packed {
    logic [3:0]        mode;
    logic [EDGE_W-1:0] left_edge;
    logic [EDGE_W-1:0] right_edge;
    logic [EDGE_W-1:0] dest_edge;
    logic              left_is_const;
    logic              right_is_const;
    val_t              left_const;
    val_t              right_const;
    logic [5:0]        shift_amount;
    val_t              input_lo;
    val_t              input_hi;
  } ire_in_t;

  typedef struct packed {
    val_t       result_lo;
    val_t       result_hi;
    logic [1:0] status;
  } ire_out_t;

  typedef struct packed {
    val_t hi;
    val_t lo;
  } ival_t;

  typedef struct packed {
    logic sat;
    val_t v;
  } sat_t;

  typedef struct packed {
    logic start;
    logic is_div;
  } md_cmd_t;

  typedef struct packed {
    logic done;
    logic sat;
    val_t value;
  } md_rsp_t;

  // Clamp a sum or difference that carries one extra bit.
  function automatic sat_t sat_wide(logic signed [VALUE_W:0] s);
    sat_t r;
    r.sat = (s[VALUE_W] != s[VALUE_W-1]);
    r.v   = r.sat ? (s[VALUE_W] ? VMIN : VMAX) : s[VALUE_W-1:0];
    return r;
  endfunction

  function automatic sat_t shl_sat(val_t a, logic [5:0] s);
    logic signed [2*VALUE_W-1:0] w;
    sat_t r;
    w     = {{VALUE_W{a[VALUE_W-1]}}, a} <<< s;
    r.sat = (a != '0) && ((s >= 6'(VALUE_W)) ||
            (w[2*VALUE_W-1:VALUE_W-1] != {(VALUE_W+1){a[VALUE_W-1]}}));
    r.v   = r.sat ? (a[VALUE_W-1] ? VMIN : VMAX) : w[VALUE_W-1:0];
    return r;
  endfunction

endpackage

`default_nettype wire

// File: design/ire_ram.sv
// Generic single-port RAM with a registered read port.
// No dependencies.
`default_nettype none

module ire_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] addr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_o <= mem_q[addr_i];
  end

endmodule

`default_nettype wire

// File: design/ire_muldiv.sv
// Shared iterative unit: one fixed-point multiply or divide corner at a time.
// Depends on ire_pkg.
`default_nettype none

module ire_muldiv
  import ire_pkg::*;
(
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  input  wire md_cmd_t cmd_i,
  input  wire val_t    a_i,
  input  wire val_t    b_i,
  output md_rsp_t      rsp_o
);

  logic                     busy_q, fin_q, div_q, neg_q;
  logic [VALUE_W-1:0]       x_q, y_q, rem_q;
  logic [2*VALUE_W-1:0]     acc_q;
  logic [NUM_W-1:0]         n_q, q_q;
  logic [5:0]               cnt_q;
  logic [5:0]               last;
  logic [VALUE_W+DIGIT_W-1:0] prod;
  logic [VALUE_W:0]         trial;
  logic [VALUE_W-1:0]       mag_a, mag_b;
  logic [2*VALUE_W-1:0]     mag_full, lim;

  assign mag_a = a_i[VALUE_W-1] ? (~a_i + 1'b1) : a_i;
  assign mag_b = b_i[VALUE_W-1] ? (~b_i + 1'b1) : b_i;
  assign last  = div_q ? 6'(NUM_W - 1) : 6'(DIGITS - 1);
  assign prod  = x_q * y_q[VALUE_W-1 -: DIGIT_W];
  assign trial = {rem_q, n_q[NUM_W-1]} - {1'b0, y_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      fin_q  <= 1'b0;
    end else begin
      fin_q <= 1'b0;
      if (cmd_i.start) begin
        busy_q <= 1'b1;
      end else if (busy_q && cnt_q == last) begin
        busy_q <= 1'b0;
        fin_q  <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.start) begin
      div_q <= cmd_i.is_div;
      neg_q <= a_i[VALUE_W-1] ^ b_i[VALUE_W-1];
      x_q   <= mag_a;
      y_q   <= mag_b;
      acc_q <= '0;
      n_q   <= {mag_a, {FRAC_BITS{1'b0}}};
      q_q   <= '0;
      rem_q <= '0;
      cnt_q <= '0;
    end else if (busy_q) begin
      cnt_q <= cnt_q + 6'd1;
      if (div_q) begin
        n_q <= {n_q[NUM_W-2:0], 1'b0};
        if (!trial[VALUE_W]) begin
          rem_q <= trial[VALUE_W-1:0];
          q_q   <= {q_q[NUM_W-2:0], 1'b1};
        end else begin
          rem_q <= {rem_q[VALUE_W-2:0], n_q[NUM_W-1]};
          q_q   <= {q_q[NUM_W-2:0], 1'b0};
        end
      end else begin
        acc_q <= {acc_q[2*VALUE_W-DIGIT_W-1:0], {DIGIT_W{1'b0}}}
               + {{(VALUE_W-DIGIT_W){1'b0}}, prod};
        y_q   <= {y_q[VALUE_W-DIGIT_W-1:0], {DIGIT_W{1'b0}}};
      end
    end
  end

  // Magnitude of the truncated result, then sign and saturation.
  assign mag_full = div_q ? {{(2*VALUE_W-NUM_W){1'b0}}, q_q} : (acc_q >> FRAC_BITS);
  assign lim      = neg_q ? {{VALUE_W{1'b0}}, 1'b1, {(VALUE_W-1){1'b0}}}
                          : {{(VALUE_W+1){1'b0}}, {(VALUE_W-1){1'b1}}};

  always_comb begin
    rsp_o.done = fin_q;
    rsp_o.sat  = (mag_full > lim);
    if (rsp_o.sat) begin
      rsp_o.value = neg_q ? VMIN : VMAX;
    end else if (neg_q) begin
      rsp_o.value = ~mag_full[VALUE_W-1:0] + 1'b1;
    end else begin
      rsp_o.value = mag_full[VALUE_W-1:0];
    end
  end

endmodule

`default_nettype wire

// File: design/interval_range_evaluator.sv
// Top level of the interval range evaluator: edge table RAM, sequencer and
// corner min/max. Depends on ire_pkg, ire_ram and ire_muldiv.
//
//   Channel  Direction  Handshake                 Payload
//   in       input      in_valid_i / in_ready_o   in_req_i  (ire_in_t)
//   out      output     out_valid_o / out_ready_i out_req_o (ire_out_t)
//
// Each request reads the left and then the right edge entry from the single
// port table RAM, then forms the result and writes it back (read writes
// nothing); constant, input, add, sub, shifts, assign and read need no more.
// Multiply runs four corners through the shared iterative unit, and so does
// divide, one quotient bit per cycle, unless the divisor interval holds zero.
// Reset clears only control state; the table holds garbage until written. A
// result waiting at the output does not stop the next request from being
// accepted; the write back waits only for the output slot.
`default_nettype none

module interval_range_evaluator
  import ire_pkg::*;
(
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     in_valid_i,
  output logic          in_ready_o,
  input  wire ire_in_t  in_req_i,
  output logic          out_valid_o,
  input  wire logic     out_ready_i,
  output ire_out_t      out_req_o
);

  typedef enum logic [5:0] {
    S_IDLE    = 6'b000001,
    S_RDR     = 6'b000010,
    S_OPS     = 6'b000100,
    S_MD_GO   = 6'b001000,
    S_MD_WAIT = 6'b010000,
    S_DONE    = 6'b100000
  } state_e;

  state_e   state_q, state_d;
  ire_in_t  req_q;
  ival_t    l_raw_q, lop_q, rop_q;
  val_t     x_lo_q, x_hi_q;
  logic     sat_q, dz_q;
  logic [1:0] corner_q;
  logic     out_valid_q;
  ire_out_t out_q;

  logic               ram_we;
  logic [EDGE_W-1:0]  ram_addr;
  logic [ENTRY_W-1:0] ram_rdata;
  ival_t              r_raw;
  val_t               l_lo, l_hi, r_lo, r_hi;
  val_t               ops_lo, ops_hi;
  logic               ops_sat, ops_dz;
  sat_t               s_lo, s_hi;
  md_cmd_t            md_cmd;
  md_rsp_t            md_rsp;
  logic               accept, known, out_free, is_md;
  status_e            status;

  assign accept   = in_valid_i && in_ready_o;
  assign known    = (in_req_i.mode <= MODE_READ);
  assign out_free = !out_valid_q || out_ready_i;
  assign in_ready_o = (state_q == S_IDLE);

  // The table RAM holds {hi, lo} for every edge.
  always_comb begin
    case (state_q)
      S_IDLE:  ram_addr = in_req_i.left_edge;
      S_RDR:   ram_addr = req_q.right_edge;
      S_DONE:  ram_addr = req_q.dest_edge;
      default: ram_addr = req_q.left_edge;
    endcase
  end

  assign ram_we = (state_q == S_DONE) && out_free && (req_q.mode != MODE_READ);

  ire_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (EDGE_COUNT)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .addr_i  (ram_addr),
    .wdata_i ({x_hi_q, x_lo_q}),
    .rdata_o (ram_rdata)
  );

  // Operands: a constant flag replaces the table entry with a point interval.
  assign r_raw = ram_rdata;
  assign l_lo  = req_q.left_is_const  ? req_q.left_const  : l_raw_q.lo;
  assign l_hi  = req_q.left_is_const  ? req_q.left_const  : l_raw_q.hi;
  assign r_lo  = req_q.right_is_const ? req_q.right_const : r_raw.lo;
  assign r_hi  = req_q.right_is_const ? req_q.right_const : r_raw.hi;
  assign is_md = (req_q.mode == MODE_MUL) || (req_q.mode == MODE_DIV);

  // Combinational operations and the zero-divisor check, evaluated once both entries are in.
  always_comb begin
    ops_lo  = l_raw_q.lo;
    ops_hi  = l_raw_q.hi;
    ops_sat = 1'b0;
    ops_dz  = 1'b0;
    s_lo    = '0;
    s_hi    = '0;
    case (req_q.mode)
      MODE_CONST: begin
        ops_lo = req_q.left_const;
        ops_hi = req_q.left_const;
      end
      MODE_INPUT: begin
        // Reversed bounds are put back in order.
        if (req_q.input_lo > req_q.input_hi) begin
          ops_lo = req_q.input_hi;
          ops_hi = req_q.input_lo;
        end else begin
          ops_lo = req_q.input_lo;
          ops_hi = req_q.input_hi;
        end
      end
      MODE_ADD: begin
        s_lo    = sat_wide({l_lo[VALUE_W-1], l_lo} + {r_lo[VALUE_W-1], r_lo});
        s_hi    = sat_wide({l_hi[VALUE_W-1], l_hi} + {r_hi[VALUE_W-1], r_hi});
        ops_lo  = s_lo.v;
        ops_hi  = s_hi.v;
        ops_sat = s_lo.sat || s_hi.sat;
      end
      MODE_SUB: begin
        // Crossed bounds keep the interval ordered.
        s_lo    = sat_wide({l_lo[VALUE_W-1], l_lo} - {r_hi[VALUE_W-1], r_hi});
        s_hi    = sat_wide({l_hi[VALUE_W-1], l_hi} - {r_lo[VALUE_W-1], r_lo});
        ops_lo  = s_lo.v;
        ops_hi  = s_hi.v;
        ops_sat = s_lo.sat || s_hi.sat;
      end
      MODE_SHL: begin
        s_lo    = shl_sat(l_lo, req_q.shift_amount);
        s_hi    = shl_sat(l_hi, req_q.shift_amount);
        ops_lo  = s_lo.v;
        ops_hi  = s_hi.v;
        ops_sat = s_lo.sat || s_hi.sat;
      end
      MODE_SHR: begin
        ops_lo = l_lo >>> req_q.shift_amount;
        ops_hi = l_hi >>> req_q.shift_amount;
      end
      MODE_DIV: begin
        // A divisor interval that spans zero gives the full range.
        ops_dz = ((r_lo <= 0) && (r_hi >= 0)) || ((r_hi <= 0) && (r_lo >= 0));
        ops_lo = VMIN;
        ops_hi = VMAX;
      end
      default: begin
        ops_lo = l_raw_q.lo;
        ops_hi = l_raw_q.hi;
      end
    endcase
  end

  // Corners go through the shared unit in the order lo*lo, lo*hi, hi*lo, hi*hi.
  assign md_cmd.start  = (state_q == S_MD_GO);
  assign md_cmd.is_div = (req_q.mode == MODE_DIV);

  ire_muldiv u_muldiv (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cmd_i  (md_cmd),
    .a_i    (corner_q[1] ? lop_q.hi : lop_q.lo),
    .b_i    (corner_q[0] ? rop_q.hi : rop_q.lo),
    .rsp_o  (md_rsp)
  );

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE:    if (accept && known) state_d = S_RDR;
      S_RDR:     state_d = S_OPS;
      S_OPS:     state_d = (is_md && !ops_dz) ? S_MD_GO : S_DONE;
      S_MD_GO:   state_d = S_MD_WAIT;
      S_MD_WAIT: begin
        if (md_rsp.done) state_d = (corner_q == 2'd3) ? S_DONE : S_MD_GO;
      end
      S_DONE:    if (out_free) state_d = S_IDLE;
      default:   state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == S_DONE && out_free) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign status = dz_q ? ST_DIVZ : (sat_q ? ST_SAT : ST_OK);

  always_ff @(posedge clk_i) begin
    if (accept) begin
      req_q <= in_req_i;
    end
    if (state_q == S_RDR) begin
      l_raw_q <= ram_rdata;
    end
    if (state_q == S_OPS) begin
      x_lo_q   <= ops_lo;
      x_hi_q   <= ops_hi;
      sat_q    <= ops_sat;
      dz_q     <= ops_dz;
      lop_q    <= {l_hi, l_lo};
      rop_q    <= {r_hi, r_lo};
      corner_q <= 2'd0;
    end
    if (state_q == S_MD_WAIT && md_rsp.done) begin
      if (corner_q == 2'd0 || md_rsp.value < x_lo_q) x_lo_q <= md_rsp.value;
      if (corner_q == 2'd0 || md_rsp.value > x_hi_q) x_hi_q <= md_rsp.value;
      sat_q    <= sat_q || md_rsp.sat;
      corner_q <= corner_q + 2'd1;
    end
    if (state_q == S_DONE && out_free) begin
      out_q.result_lo <= x_lo_q;
      out_q.result_hi <= x_hi_q;
      out_q.status    <= status;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_req_o   = out_q;

endmodule

`default_nettype wire

// File: design/ire_checker.sv
// Port-level checks for the interval range evaluator, bound to the top level.
// Depends on ire_pkg.
`default_nettype none

module ire_checker
  import ire_pkg::*;
(
  input wire logic     clk_i,
  input wire logic     rst_ni,
  input wire logic     in_valid_i,
  input wire logic     in_ready_i,
  input wire ire_in_t  in_req_i,
  input wire logic     out_valid_i,
  input wire logic     out_ready_i,
  input wire ire_out_t out_req_i
);

  // A held result stays up and unchanged.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_req_i))
    else $error("held result dropped or changed");

  // A zero-spanning divisor reports the full range.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_req_i.status == ST_DIVZ |->
      out_req_i.result_lo == VMIN && out_req_i.result_hi == VMAX)
    else $error("divide-by-zero result is not the full range");

  // A known request drops ready in the cycle after it is accepted.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i && in_req_i.mode <= MODE_READ |=> !in_ready_i)
    else $error("ready stayed high after a known request");

  // An unknown operation is dropped and the block stays ready.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i && in_req_i.mode > MODE_READ |=> in_ready_i)
    else $error("unknown request was not dropped");

endmodule

bind interval_range_evaluator ire_checker u_ire_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_i  (in_ready_o),
  .in_req_i    (in_req_i),
  .out_valid_i (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_req_i   (out_req_o)
);

`default_nettype wire

// File: tb/ire_checker.sv
// Checker for the interval range evaluator: watches both channels, predicts
// each result from its own copy of the edge table, and counts mismatches.
// Depends on ire_pkg.
`timescale 1ns / 100ps

module ire_scoreboard
  import ire_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  input  logic     in_ready_i,
  input  ire_in_t  in_req_i,
  input  logic     out_valid_i,
  input  logic     out_ready_i,
  input  ire_out_t out_req_i,
  output int       errors_o,
  output int       pending_o
);

  typedef logic signed [127:0] wide_t;

  ival_t    range_table [EDGE_COUNT];
  ire_out_t want_q [$];
  int       errors = 0;
  int       pending = 0;

  assign errors_o  = errors;
  assign pending_o = pending;

  task automatic report(string msg);
    $display("MISMATCH at %0t: %s", $realtime, msg);
    errors++;
  endtask

  function automatic val_t clamp(wide_t r, inout bit sat);
    if (r > wide_t'(VMAX)) begin
      sat = 1;
      return VMAX;
    end
    if (r < wide_t'(VMIN)) begin
      sat = 1;
      return VMIN;
    end
    return val_t'(r);
  endfunction

  function automatic wide_t magnitude(val_t a);
    wide_t w;
    w = wide_t'(a);
    return (w < 0) ? -w : w;
  endfunction

  // Magnitude and sign recombined; the product or quotient truncates toward zero.
  function automatic val_t signed_of(bit neg, wide_t m, inout bit sat);
    return clamp(neg ? -m : m, sat);
  endfunction

  function automatic val_t q_mul(val_t a, val_t b, inout bit sat);
    wide_t m;
    m = (magnitude(a) * magnitude(b)) >>> FRAC_BITS;
    return signed_of(a[VALUE_W-1] ^ b[VALUE_W-1], m, sat);
  endfunction

  function automatic val_t q_div(val_t a, val_t b, inout bit sat);
    wide_t m;
    m = (magnitude(a) <<< FRAC_BITS) / magnitude(b);
    return signed_of(a[VALUE_W-1] ^ b[VALUE_W-1], m, sat);
  endfunction

  function automatic val_t shift_up(val_t a, logic [5:0] s, inout bit sat);
    if (a == 0) return '0;
    if (s >= 6'(VALUE_W)) begin
      sat = 1;
      return a[VALUE_W-1] ? VMIN : VMAX;
    end
    return clamp(wide_t'(a) <<< s, sat);
  endfunction

  // Computes the interval of one node and updates the table copy.
  function automatic ire_out_t evaluate_node(ire_in_t q);
    val_t     llo, lhi, rlo, rhi, xlo, xhi, t;
    val_t     c [4];
    bit       sat, divz, store;
    ire_out_t r;
    sat   = 0;
    divz  = 0;
    store = 1;
    llo = range_table[q.left_edge].lo;
    lhi = range_table[q.left_edge].hi;
    rlo = range_table[q.right_edge].lo;
    rhi = range_table[q.right_edge].hi;
    if (q.left_is_const) begin
      llo = q.left_const;
      lhi = q.left_const;
    end
    if (q.right_is_const) begin
      rlo = q.right_const;
      rhi = q.right_const;
    end
    xlo = '0;
    xhi = '0;
    case (q.mode)
      MODE_CONST: begin
        xlo = q.left_const;
        xhi = q.left_const;
      end
      MODE_INPUT: begin
        xlo = q.input_lo;
        xhi = q.input_hi;
        if (xlo > xhi) begin
          t = xlo; xlo = xhi; xhi = t;
        end
      end
      MODE_ADD: begin
        xlo = clamp(wide_t'(llo) + wide_t'(rlo), sat);
        xhi = clamp(wide_t'(lhi) + wide_t'(rhi), sat);
      end
      MODE_SUB: begin
        xlo = clamp(wide_t'(llo) - wide_t'(rhi), sat);
        xhi = clamp(wide_t'(lhi) - wide_t'(rlo), sat);
      end
      MODE_MUL, MODE_DIV: begin
        if (q.mode == MODE_DIV &&
            ((rlo <= 0 && rhi >= 0) || (rhi <= 0 && rlo >= 0))) begin
          divz = 1;
          xlo  = VMIN;
          xhi  = VMAX;
        end else begin
          if (q.mode == MODE_MUL) begin
            c[0] = q_mul(llo, rlo, sat); c[1] = q_mul(llo, rhi, sat);
            c[2] = q_mul(lhi, rlo, sat); c[3] = q_mul(lhi, rhi, sat);
          end else begin
            c[0] = q_div(llo, rlo, sat); c[1] = q_div(llo, rhi, sat);
            c[2] = q_div(lhi, rlo, sat); c[3] = q_div(lhi, rhi, sat);
          end
          xlo = c[0];
          xhi = c[0];
          for (int i = 1; i < 4; i++) begin
            if (c[i] < xlo) xlo = c[i];
            if (c[i] > xhi) xhi = c[i];
          end
        end
      end
      MODE_SHL: begin
        xlo = shift_up(llo, q.shift_amount, sat);
        xhi = shift_up(lhi, q.shift_amount, sat);
      end
      MODE_SHR: begin
        xlo = llo >>> q.shift_amount;
        xhi = lhi >>> q.shift_amount;
      end
      default: begin
        // Assign and read both copy the stored entry; read leaves the table alone.
        xlo   = range_table[q.left_edge].lo;
        xhi   = range_table[q.left_edge].hi;
        store = (q.mode == MODE_ASSIGN);
      end
    endcase
    if (store) begin
      range_table[q.dest_edge].lo = xlo;
      range_table[q.dest_edge].hi = xhi;
    end
    r.result_lo = xlo;
    r.result_hi = xhi;
    r.status    = divz ? ST_DIVZ : (sat ? ST_SAT : ST_OK);
    return r;
  endfunction

  always @(posedge clk_i) begin
    ire_out_t w;
    if (rst_ni) begin
      if (out_valid_i && out_ready_i) begin
        if (want_q.size() == 0) begin
          report("result with no request waiting");
        end else begin
          w = want_q.pop_front();
          if (out_req_i.result_lo !== w.result_lo)
            report($sformatf("result_lo %0d, predicted %0d",
                             out_req_i.result_lo, w.result_lo));
          if (out_req_i.result_hi !== w.result_hi)
            report($sformatf("result_hi %0d, predicted %0d",
                             out_req_i.result_hi, w.result_hi));
          if (out_req_i.status !== w.status)
            report($sformatf("status %0d, predicted %0d", out_req_i.status, w.status));
        end
      end
      if (in_valid_i && in_ready_i && in_req_i.mode <= MODE_READ)
        want_q.push_back(evaluate_node(in_req_i));
      pending = want_q.size();
    end
  end

endmodule

// File: tb/interval_range_evaluator_tb.sv
// Testbench top for the interval range evaluator: clock, reset, request
// stimulus with random gaps, result back-pressure and the verdict.
// Depends on ire_pkg, ire_scoreboard and the block itself.
`timescale 1ns / 100ps

module interval_range_evaluator_tb
  import ire_pkg::*;
();

  localparam int IDLE_LIMIT = 5000;
  localparam int HOLD_OFF   = 600;

  logic     clk;
  logic     rst_n;
  logic     in_valid;
  logic     in_ready;
  ire_in_t  in_req;
  logic     out_valid;
  logic     out_ready;
  ire_out_t out_req;
  int       errors;
  int       pending;
  bit       hold_off_now;

  // Edges that hold a value; once there are any, operands are drawn only from
  // these so that requests read no table entry that was never written.
  bit written [EDGE_COUNT];
  int written_list [$];

  interval_range_evaluator i_dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_req_i    (in_req),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_req_o   (out_req)
  );

  ire_scoreboard i_checker (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_ready_i  (in_ready),
    .in_req_i    (in_req),
    .out_valid_i (out_valid),
    .out_ready_i (out_ready),
    .out_req_i   (out_req),
    .errors_o    (errors),
    .pending_o   (pending)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Watchdog: the run ends if nothing moves on either channel for too long.
  initial begin
    int idle;
    idle = 0;
    forever begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready)) idle = 0;
      else idle++;
      if (idle >= IDLE_LIMIT) begin
        $display("end of test: mismatches");
        $finish;
      end
    end
  end

  // Receiver: random stall before each result, and one long hold-off on request
  // so that the block backs up and drops in_ready.
  initial begin
    int gap;
    bit held;
    held = 1'b0;
    out_ready = 1'b0;
    @(posedge clk iff rst_n);
    forever begin
      if (hold_off_now && !held) begin
        out_ready <= 1'b0;
        repeat (HOLD_OFF) @(posedge clk);
        held = 1'b1;
      end
      gap = (($urandom % 4) == 0) ? 0 : $urandom_range(0, 14);
      if (gap > 0) begin
        out_ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
    end
  end

  function automatic val_t pick_value();
    case ($urandom % 7)
      0: return VMAX;
      1: return VMIN;
      2: return '0;
      3: return val_t'($signed($urandom_range(0, 2 ** 22))) - val_t'(2 ** 21);
      4: return val_t'({$urandom, $urandom});
      5: return ($urandom % 2) ? val_t'(1 << FRAC_BITS) : -val_t'(1 << FRAC_BITS);
      default: return val_t'($signed($urandom)) >>> $urandom_range(0, 16);
    endcase
  endfunction

  function automatic logic [EDGE_W-1:0] pick_operand();
    if (written_list.size() == 0) return EDGE_W'($urandom);
    return EDGE_W'(written_list[$urandom_range(0, written_list.size() - 1)]);
  endfunction

  function automatic ire_in_t build_request(logic [3:0] m, int oe);
    ire_in_t r;
    r.mode           = m;
    r.left_edge      = pick_operand();
    r.right_edge     = pick_operand();
    r.dest_edge      = EDGE_W'(oe);
    r.left_is_const  = $urandom % 4 == 0;
    r.right_is_const = $urandom % 4 == 0;
    r.left_const     = pick_value();
    r.right_const    = pick_value();
    r.shift_amount   = 6'($urandom_range(0, 47));
    r.input_lo       = pick_value();
    r.input_hi       = pick_value();
    return r;
  endfunction

  // Offers one request after a random gap and waits until it is accepted.
  task automatic send(ire_in_t r);
    int gap;
    gap = (($urandom % 4) == 0) ? 0 : $urandom_range(0, 14);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_req   <= r;
    in_valid <= 1'b1;
    do @(posedge clk); while (!in_ready);
    if ((r.mode == MODE_CONST || r.mode == MODE_INPUT || r.mode == MODE_ADD ||
         r.mode == MODE_SUB || r.mode == MODE_MUL || r.mode == MODE_DIV ||
         r.mode == MODE_SHL || r.mode == MODE_SHR || r.mode == MODE_ASSIGN) &&
        !written[r.dest_edge]) begin
      written[r.dest_edge] = 1;
      written_list.push_back(int'(r.dest_edge));
    end
  endtask

  initial begin
    ire_in_t r;
    int      sent;
    logic [3:0] m;
    rst_n        = 1'b0;
    in_valid     = 1'b0;
    in_req       = '0;
    hold_off_now = 0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part: extremes, each operation and the named corner cases.
    r = build_request(MODE_CONST, 0);    r.left_const = VMAX;        send(r);
    r = build_request(MODE_CONST, 1023); r.left_const = VMIN;        send(r);
    r = build_request(MODE_INPUT, 2);    r.input_lo = val_t'(5 << 16);
    r.input_hi = -val_t'(3 << 16);                                   send(r);
    r = build_request(MODE_INPUT, 3);    r.input_lo = VMIN; r.input_hi = VMAX; send(r);
    r = build_request(MODE_ADD, 4);      r.left_edge = 0; r.right_edge = 0;
    r.left_is_const = 0; r.right_is_const = 0;                       send(r);
    r = build_request(MODE_SUB, 5);      r.left_edge = 1023; r.right_edge = 0;
    r.left_is_const = 0; r.right_is_const = 0;                       send(r);
    // Constant minus interval keeps the bounds ordered.
    r = build_request(MODE_SUB, 6);      r.left_is_const = 1; r.left_const = '0;
    r.right_edge = 2; r.right_is_const = 0;                          send(r);
    r = build_request(MODE_MUL, 7);      r.left_edge = 3; r.right_edge = 2;
    r.left_is_const = 0; r.right_is_const = 0;                       send(r);
    r = build_request(MODE_MUL, 8);      r.left_is_const = 1; r.right_is_const = 1;
    r.left_const = VMIN; r.right_const = VMIN;                       send(r);
    r = build_request(MODE_DIV, 9);      r.left_edge = 2; r.left_is_const = 0;
    r.right_is_const = 1; r.right_const = val_t'(3 << 16);           send(r);
    // Divisor interval holding zero, once as a point and once as a range.
    r = build_request(MODE_DIV, 10);     r.right_is_const = 1; r.right_const = '0; send(r);
    r = build_request(MODE_DIV, 11);     r.right_edge = 2; r.right_is_const = 0; send(r);
    r = build_request(MODE_DIV, 12);     r.left_is_const = 1; r.left_const = VMAX;
    r.right_is_const = 1; r.right_const = val_t'(1);                 send(r);
    r = build_request(MODE_SHL, 13);     r.left_edge = 2; r.left_is_const = 0;
    r.shift_amount = 6'd47;                                          send(r);
    r = build_request(MODE_SHL, 14);     r.left_edge = 2; r.left_is_const = 0;
    r.shift_amount = 6'd0;                                           send(r);
    r = build_request(MODE_SHR, 15);     r.left_edge = 1023; r.left_is_const = 0;
    r.shift_amount = 6'd47;                                          send(r);
    r = build_request(MODE_SHR, 16);     r.left_is_const = 1; r.left_const = -val_t'(1);
    r.shift_amount = 6'd3;                                           send(r);
    r = build_request(MODE_ASSIGN, 17);  r.left_edge = 7; r.left_is_const = 1; send(r);
    r = build_request(MODE_READ, 18);    r.left_edge = 17;           send(r);
    r = build_request(MODE_READ, 0);     r.left_edge = 1023;         send(r);
    // Unknown operations are dropped without a result.
    r = build_request(4'd10, 19);                                    send(r);
    r = build_request(4'd15, 20);                                    send(r);

    // Random part, with one long receiver hold-off at its start.
    hold_off_now = 1;
    sent = 0;
    while (sent < 430) begin
      if ($urandom % 20 == 0) m = 4'($urandom_range(10, 15));
      else m = 4'($urandom_range(0, 9));
      r = build_request(m, $urandom_range(0, EDGE_COUNT - 1));
      send(r);
      sent++;
    end
    in_valid <= 1'b0;

    while (pending != 0) @(posedge clk);
    repeat (300) @(posedge clk);
    if (errors == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

// File: filelist.f
design/ire_pkg.sv
design/ire_ram.sv
design/ire_muldiv.sv
design/interval_range_evaluator.sv
design/ire_checker.sv
tb/ire_checker.sv
tb/interval_range_evaluator_tb.sv
